/* rtl/isort_pkg.sv */
// isort_pkg: item types and cell control for the insertion sorter
// no dependencies; imported by isort_cell, insertion_sorter, isort_checker and tb
`timescale 1ns / 1ps

package isort_pkg;

	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     overflow;
	} out_item_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

/* rtl/isort_cell.sv */
// isort_cell: one slot of the sorting chain, compare-and-shift on insert,
// shift towards the head on drain; depends on isort_pkg
`timescale 1ns / 1ps

module isort_cell
	import isort_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] key,
	input  logic                     prev_gt,
	input  logic signed [DATA_W-1:0] prev_value,
	input  logic                     prev_valid,
	input  logic signed [DATA_W-1:0] next_value,
	input  logic                     next_valid,
	output logic                     gt,
	output logic signed [DATA_W-1:0] value,
	output logic                     valid
);

	logic signed [DATA_W-1:0] value_q;
	logic                     valid_q;

	// empty slots count as greater than any key
	assign gt    = !valid_q || (value_q > key);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.ins && gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= next_value;
		end else if (ctl.ins && gt) begin
			value_q <= prev_gt ? prev_value : key;
		end
	end

endmodule

/* rtl/insertion_sorter.sv */
// insertion_sorter: stable sorter built from a chain of isort_cell slots
// depends on isort_pkg and isort_cell
//
//  port     dir  handshake        content
//  item     in   start & !busy    value, last
//  result   out  strobe           sorted_value, final_res, overflow
//
// one item is taken per cycle while busy is low; once all slots are full, items are dropped and flag overflow
// an item marked last starts a drain: n results come out back to back
// (n = stored count), and busy is high for the whole drain
// reset clears all slot valid bits, the count and the overflow flag
// results cannot be held off; each is on the port for one cycle only
`timescale 1ns / 1ps

module insertion_sorter
	import isort_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      strobe,
	output out_item_t result
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic                     drain_q;
	logic [CNT_W-1:0]         count_q;
	logic                     dropped_q;
	logic                     strobe_q;
	out_item_t                result_q;

	logic                     accept;
	logic                     full;
	cell_ctl_t                ctl;

	logic                     gts    [CAPACITY];
	logic signed [DATA_W-1:0] vals   [CAPACITY];
	logic                     valids [CAPACITY];

	assign accept    = start && !drain_q;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign ctl.ins   = accept && !full;
	assign ctl.shift = drain_q;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				isort_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctl        (ctl),
					.key        (item.value),
					.prev_gt    (1'b0),
					.prev_value ('0),
					.prev_valid (1'b0),
					.next_value (vals[gi+1]),
					.next_valid (valids[gi+1]),
					.gt         (gts[gi]),
					.value      (vals[gi]),
					.valid      (valids[gi])
				);
			end else if (gi == CAPACITY - 1) begin : g_tail
				isort_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctl        (ctl),
					.key        (item.value),
					.prev_gt    (gts[gi-1]),
					.prev_value (vals[gi-1]),
					.prev_valid (valids[gi-1]),
					.next_value ('0),
					.next_valid (1'b0),
					.gt         (gts[gi]),
					.value      (vals[gi]),
					.valid      (valids[gi])
				);
			end else begin : g_mid
				isort_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctl        (ctl),
					.key        (item.value),
					.prev_gt    (gts[gi-1]),
					.prev_value (vals[gi-1]),
					.prev_valid (valids[gi-1]),
					.next_value (vals[gi+1]),
					.next_valid (valids[gi+1]),
					.gt         (gts[gi]),
					.value      (vals[gi]),
					.valid      (valids[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			count_q   <= '0;
			dropped_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= drain_q;
			if (drain_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					drain_q   <= 1'b0;
					dropped_q <= 1'b0;
				end
			end else if (accept) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				drain_q <= item.last;
			end
		end
	end

	// head slot goes out while the chain moves up
	always_ff @(posedge clk) begin
		if (drain_q) begin
			result_q.sorted_value <= vals[0];
			result_q.final_res    <= (count_q == CNT_W'(1));
			result_q.overflow     <= dropped_q;
		end
	end

	assign busy   = drain_q;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

/* dv/isort_checker.sv */
// isort_checker: watches the item and result ports of insertion_sorter,
// predicts each sorted run and compares it with what the block emits
// depends on isort_pkg
`timescale 1ns / 1ps

module isort_checker
	import isort_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  item,
	input  logic      strobe,
	input  out_item_t result,
	output int        errors,
	output int        pending,
	output int        items_seen,
	output int        runs_seen,
	output int        results_seen,
	output int        overflow_runs
);

	logic signed [DATA_W-1:0] held[$];
	logic                     held_drop;
	out_item_t                sorted_due[$];

	task automatic insert_sorted(input in_item_t it);
		int        pos;
		out_item_t r;
		if (held.size() >= CAPACITY) begin
			held_drop = 1'b1;
		end else begin
			pos = held.size();
			while (pos > 0 && held[pos-1] > it.value)
				pos--;
			held.insert(pos, it.value);
		end
		if (it.last) begin
			foreach (held[k]) begin
				r.sorted_value = held[k];
				r.final_res    = (k == held.size() - 1);
				r.overflow     = held_drop;
				sorted_due.push_back(r);
			end
			runs_seen++;
			if (held_drop)
				overflow_runs++;
			held.delete();
			held_drop = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			held.delete();
			sorted_due.delete();
			held_drop     = 1'b0;
			errors        = 0;
			items_seen    = 0;
			runs_seen     = 0;
			results_seen  = 0;
			overflow_runs = 0;
		end else begin
			if (strobe) begin
				results_seen++;
				if (sorted_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result value %0d final %0b overflow %0b",
						$time, result.sorted_value, result.final_res, result.overflow);
				end else begin
					want = sorted_due.pop_front();
					if (result.sorted_value !== want.sorted_value ||
						result.final_res !== want.final_res ||
						result.overflow !== want.overflow) begin
						errors++;
						$display("%0t: expected value %0d final %0b overflow %0b, %s",
							$time, want.sorted_value, want.final_res, want.overflow,
							$sformatf("got value %0d final %0b overflow %0b",
								result.sorted_value, result.final_res, result.overflow));
					end
				end
			end
			if (start && !busy) begin
				items_seen++;
				insert_sorted(item);
			end
		end
		pending = sorted_due.size();
	end

endmodule

/* dv/tb.sv */
// tb: drives sets of signed values into insertion_sorter in random bursts
// and gives the verdict; prediction and comparison live in isort_checker
// depends on isort_pkg, insertion_sorter and isort_checker
`timescale 1ns / 1ps

module tb;
	import isort_pkg::*;

	localparam int unsigned CAPACITY = 64;
	localparam int          QUIET_LIMIT = 5000;
	localparam int          RANDOM_ITEMS = 200;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_item_t  item = '0;
	logic      strobe;
	out_item_t result;

	int errors, pending, items_seen, runs_seen, results_seen, overflow_runs;
	int burst_left = 0;
	int sent = 0;
	int quiet = 0;

	always #5 clk = ~clk;

	insertion_sorter #(.CAPACITY(CAPACITY)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.strobe(strobe),
		.result(result)
	);

	isort_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.strobe       (strobe),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.items_seen   (items_seen),
		.runs_seen    (runs_seen),
		.results_seen (results_seen),
		.overflow_runs(overflow_runs)
	);

	// nothing moving for too long means a hang or a missing result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no activity for %0d cycles, %0d results still due",
					$time, QUIET_LIMIT, pending);
				$display("insertion_sorter verification failed");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 8)) - 4;
			1: case ($urandom_range(0, 4))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0000_0000;
				3: return -32'sd1;
				default: return 32'sd1;
			endcase
			2: return 32'sh8000_0000 + $urandom_range(0, 3);
			3: return 32'sh7fff_ffff - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	task automatic rest(input int n);
		@(negedge clk);
		start <= 1'b0;
		item  <= {$urandom, 1'($urandom)};
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send(input logic signed [31:0] v, input logic lst);
		if (burst_left == 0) begin
			rest($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		item  <= '{value: v, last: lst};
		do @(posedge clk); while (busy !== 1'b0);
		sent++;
	endtask

	task automatic send_set(input int len);
		for (int i = 0; i < len; i++)
			send(pick_value(), i == len - 1);
	endtask

	initial begin
		int len;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// extremes of the value range in one set
		send(32'sd0, 1'b0);
		send(32'sh7fff_ffff, 1'b0);
		send(32'sh8000_0000, 1'b0);
		send(-32'sd1, 1'b0);
		send(32'sd1, 1'b0);
		send(32'sh8000_0001, 1'b0);
		send(32'sh7fff_fffe, 1'b1);
		// single item run
		send(32'sd5, 1'b1);
		// equal values among others
		send(32'sd3, 1'b0);
		send(-32'sd3, 1'b0);
		send(32'sd3, 1'b0);
		send(32'sd3, 1'b0);
		send(-32'sd3, 1'b1);
		// descending input
		for (int i = 0; i < 5; i++)
			send(32'sd100 - 32'sd40 * i, i == 4);

		// store exactly full, then a set whose tail and last item are dropped
		send_set(CAPACITY);
		send_set(CAPACITY + 3);
		while (sent < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
				: $urandom_range(1, 10);
			send_set(len);
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);

		$display("run covered %0d items in %0d sets, %0d sorted results checked",
			items_seen, runs_seen, results_seen);
		$display("%0d sets overflowed the store of %0d entries", overflow_runs, CAPACITY);
		if (errors == 0)
			$display("insertion_sorter verification clean");
		else
			$display("insertion_sorter verification failed");
		$finish;
	end

endmodule
